// ----- src/sfsg_pkg.sv -----
// Shared types, constants and helpers for the stroke font segment generator.
`timescale 1ns / 1ps

package sfsg_pkg;

   // default store sizes
   localparam int DEF_GLYPH_COUNT  = 128;
   localparam int DEF_PATH_DEPTH   = 1024;
   localparam int DEF_VERTEX_DEPTH = 4096;
   localparam int DEF_MAX_SEGMENTS = 64;

   // codes at or above this limit draw nothing
   localparam int CODE_LIMIT = 128;

   // scale of 25600 maps font units one to one; 25600 = 25 << 10
   localparam int          UNIT_SCALE  = 25600;
   localparam int          UNIT_SHIFT  = 10;
   localparam int          UNIT_ODD    = UNIT_SCALE >> UNIT_SHIFT;
   localparam logic [17:0] SCALE_RESET = 18'(UNIT_SCALE);

   // divide by 25 as multiply by reciprocal, exact for 17-bit dividends
   localparam int DIV_SHIFT = 22;
   localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + UNIT_ODD - 1) / UNIT_ODD;

   // field and datapath widths
   localparam int SCALE_W  = 18;
   localparam int VERT_W   = 10;
   localparam int COORD_W  = 16;
   localparam int COUNT_W  = 6;
   localparam int ADV_W    = 8;
   localparam int INDEX_W  = 12;
   localparam int PROD_W   = VERT_W + SCALE_W + 1;
   localparam int MAG_W    = 17;
   localparam int RECIP_W  = 18;
   localparam int Q_W      = MAG_W + RECIP_W;
   localparam int QUO_W    = Q_W - DIV_SHIFT;
   localparam int SCALED_W = QUO_W + 1;

   typedef enum logic [2:0] {
      MODE_LOAD_GLYPH  = 3'd0,
      MODE_LOAD_PATH   = 3'd1,
      MODE_LOAD_VERTEX = 3'd2,
      MODE_SET_PEN     = 3'd3,
      MODE_DRAW        = 3'd4
   } mode_type;

   // what a token in the scaling pipe stands for
   typedef enum logic [1:0] {
      TOK_FIRST = 2'd0,   // first vertex of a path
      TOK_NEXT  = 2'd1,   // further vertex, closes a segment
      TOK_ADV   = 2'd2    // pen advance at end of character
   } tok_kind_type;

   typedef struct packed {
      logic         valid;
      tok_kind_type kind;
   } tok_type;

   // value mod depth, for value < 4096 and depth >= 128
   function automatic logic [INDEX_W-1:0] wrap_index(input logic [INDEX_W-1:0] value,
                                                     input int depth);
      logic [17:0] rem;
      logic [17:0] sub;
      rem = 18'(value);
      for (int k = 5; k >= 0; k--) begin
         sub = 18'(depth) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[INDEX_W-1:0];
   endfunction

endpackage

// ----- src/stroke_font_segment_generator_unit.sv -----
// Top level of the stroke font segment generator: stores, walker, scaler, output.
`timescale 1ns / 1ps

// Vector text generator.
// req channel: one word per item. tuser carries the mode: load glyph, load
//   path, load vertex, set pen or draw character. Loads and set pen produce
//   nothing. A draw of a code below 128 walks the glyph's paths and sends one
//   rsp word per vertex pair; tlast marks the final segment of the character.
// csr port: csr_we writes the 18-bit scale (25600 = one font unit per pixel).
// A draw occupies the block until its advance token has left the scaler, and
//   no new word is taken meanwhile; the vertex store's read port gives one
//   vertex per cycle while the output is not stalled.
// The first segment passes the glyph read, path read, vertex read, three
//   scaler stages and the pairing step, which holds one segment back.
// Reset clears pen to zero, scale to 25600 and all control state; the font
//   stores hold garbage until loaded and there is no clearing pass.
// With rsp_tvalid high and rsp_tready low the whole vertex pipe holds; the walker
//   stalls its vertex reads and accepts no new item until the pipe drains.
module stroke_font_segment_generator_unit
   import sfsg_pkg::*;
#(
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
   parameter int PATH_DEPTH   = DEF_PATH_DEPTH,
   parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata: table_index[11:0], char_code[19:12], pen_x[35:20], pen_y[51:36],
   //        start_index[63:52], item_count[69:64], advance[77:70],
   //        vertex_x[87:78], vertex_y[97:88], zero fill[103:98]
   input  logic [103:0]         req_tdata,
   // tuser: mode[2:0]
   input  logic [2:0]           req_tuser,
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata: seg_x1[15:0], seg_y1[31:16], seg_x2[47:32], seg_y2[63:48]
   output logic [63:0]          rsp_tdata,
   output logic                 rsp_tlast,   // last_segment
   // scale register
   input  logic                 csr_we,
   input  logic [SCALE_W-1:0]   csr_wdata
);

   localparam int GW      = $clog2(GLYPH_COUNT);
   localparam int PPW     = $clog2(PATH_DEPTH);
   localparam int VPW     = $clog2(VERTEX_DEPTH);
   localparam int GLYPH_W = ADV_W + COUNT_W + PPW;
   localparam int PATH_W  = COUNT_W + VPW;
   localparam int VREC_W  = 2 * VERT_W;

   // request word fields
   logic [INDEX_W-1:0]       f_index;
   logic [7:0]               f_code;
   logic [COORD_W-1:0]       f_pen_x, f_pen_y;
   logic [INDEX_W-1:0]       f_start;
   logic [COUNT_W-1:0]       f_count;
   logic [ADV_W-1:0]         f_width;
   logic [VERT_W-1:0]        f_vx, f_vy;
   mode_type                 mode;
   logic                     req_fire;

   assign f_index  = req_tdata[11:0];
   assign f_code   = req_tdata[19:12];
   assign f_pen_x  = req_tdata[35:20];
   assign f_pen_y  = req_tdata[51:36];
   assign f_start  = req_tdata[63:52];
   assign f_count  = req_tdata[69:64];
   assign f_width  = req_tdata[77:70];
   assign f_vx     = req_tdata[87:78];
   assign f_vy     = req_tdata[97:88];
   assign mode     = mode_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;

   // pipe advance: output register empty or being drained
   logic rsp_valid_ff, rsp_valid_in;
   logic en;
   assign en = !rsp_valid_ff || rsp_tready;

   // store ports
   logic               glyph_we, path_we, vert_we;
   logic [GLYPH_W-1:0] glyph_wdata, glyph_rdata;
   logic [PATH_W-1:0]  path_wdata, path_rdata;
   logic [VREC_W-1:0]  vert_wdata, vert_rdata;
   logic               glyph_re, path_re, vert_re;
   logic [GW-1:0]      glyph_raddr;
   logic [PPW-1:0]     path_raddr;
   logic [VPW-1:0]     vert_raddr;

   assign glyph_we = req_fire && mode == MODE_LOAD_GLYPH
                     && 13'(f_index) < 13'(GLYPH_COUNT);
   assign path_we  = req_fire && mode == MODE_LOAD_PATH
                     && 13'(f_index) < 13'(PATH_DEPTH);
   assign vert_we  = req_fire && mode == MODE_LOAD_VERTEX
                     && 13'(f_index) < 13'(VERTEX_DEPTH);

   assign glyph_wdata = {f_width, f_count, PPW'(wrap_index(f_start, PATH_DEPTH))};
   assign path_wdata  = {f_count, VPW'(wrap_index(f_start, VERTEX_DEPTH))};
   assign vert_wdata  = {f_vy, f_vx};

   sfsg_ram #(.WIDTH(GLYPH_W), .DEPTH(GLYPH_COUNT)) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (f_index[GW-1:0]),
      .wr_data (glyph_wdata),
      .rd_en   (glyph_re),
      .rd_addr (glyph_raddr),
      .rd_data (glyph_rdata)
   );

   sfsg_ram #(.WIDTH(PATH_W), .DEPTH(PATH_DEPTH)) u_path_ram (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (f_index[PPW-1:0]),
      .wr_data (path_wdata),
      .rd_en   (path_re),
      .rd_addr (path_raddr),
      .rd_data (path_rdata)
   );

   sfsg_ram #(.WIDTH(VREC_W), .DEPTH(VERTEX_DEPTH)) u_vert_ram (
      .clock   (clock),
      .wr_en   (vert_we),
      .wr_addr (f_index[VPW-1:0]),
      .wr_data (vert_wdata),
      .rd_en   (vert_re),
      .rd_addr (vert_raddr),
      .rd_data (vert_rdata)
   );

   // walker
   logic             draw_start;
   logic             walk_idle;
   tok_type          walk_tok;
   logic [ADV_W-1:0] walk_adv;
   logic             pipe_busy;

   assign draw_start = req_fire && mode == MODE_DRAW
                       && 9'(f_code) < 9'(CODE_LIMIT) && 9'(f_code) < 9'(GLYPH_COUNT);

   sfsg_walker #(
      .GLYPH_COUNT  (GLYPH_COUNT),
      .PATH_DEPTH   (PATH_DEPTH),
      .VERTEX_DEPTH (VERTEX_DEPTH),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .draw_start    (draw_start),
      .code          (f_code),
      .glyph_rd_en   (glyph_re),
      .glyph_rd_addr (glyph_raddr),
      .glyph_rd_data (glyph_rdata),
      .path_rd_en    (path_re),
      .path_rd_addr  (path_raddr),
      .path_rd_data  (path_rdata),
      .vert_rd_en    (vert_re),
      .vert_rd_addr  (vert_raddr),
      .tok           (walk_tok),
      .adv           (walk_adv),
      .pipe_busy     (pipe_busy),
      .idle          (walk_idle)
   );

   assign req_tready = walk_idle;

   // scaler; the advance token rides the x lane with the glyph width
   logic signed [VERT_W-1:0]   sc_in_x, sc_in_y;
   tok_type                    sc_tok;
   logic signed [SCALED_W-1:0] sc_x, sc_y;
   logic [SCALE_W-1:0]         scale_ff, scale_in;

   assign sc_in_x = (walk_tok.kind == TOK_ADV) ? $signed({2'b00, walk_adv})
                                               : $signed(vert_rdata[VERT_W-1:0]);
   assign sc_in_y = $signed(vert_rdata[VREC_W-1:VERT_W]);

   sfsg_scale_pipe u_scale (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tok  (walk_tok),
      .in_x    (sc_in_x),
      .in_y    (sc_in_y),
      .scale   (scale_ff),
      .out_tok (sc_tok),
      .out_x   (sc_x),
      .out_y   (sc_y),
      .busy    (pipe_busy)
   );

   // pen offset: x adds, y subtracts (screen y grows downward)
   logic [COORD_W-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [COORD_W-1:0] pt_x, pt_y;

   assign pt_x = pen_x_ff + {{(COORD_W-SCALED_W){sc_x[SCALED_W-1]}}, sc_x};
   assign pt_y = pen_y_ff - {{(COORD_W-SCALED_W){sc_y[SCALED_W-1]}}, sc_y};

   // pairing: one segment is held back so the last one can be tagged
   logic [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [63:0]        pend_seg_ff, pend_seg_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   always_comb begin
      scale_in      = csr_we ? csr_wdata : scale_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      pend_valid_in = pend_valid_ff;
      pend_seg_in   = pend_seg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_fire && mode == MODE_SET_PEN) begin
         pen_x_in = f_pen_x;
         pen_y_in = f_pen_y;
      end
      if (en) begin
         rsp_valid_in = 1'b0;
         if (sc_tok.valid) begin
            case (sc_tok.kind)
               TOK_FIRST: begin
                  prev_x_in = pt_x;
                  prev_y_in = pt_y;
               end
               TOK_NEXT: begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_seg_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_seg_in   = {pt_y, pt_x, prev_y_ff, prev_x_ff};
                  prev_x_in     = pt_x;
                  prev_y_in     = pt_y;
               end
               TOK_ADV: begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_seg_ff;
                     rsp_last_in  = 1'b1;
                  end
                  pend_valid_in = 1'b0;
                  pen_x_in      = pt_x;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_RESET;
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scale_ff      <= scale_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      pend_seg_ff <= pend_seg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !pend_valid_ff)
      else $error("segment still held after last word");

   a_ready_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("ready while a segment is held back");

   a_ready_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pipe_busy)
      else $error("ready while the scaler holds tokens");
`endif

endmodule

// ----- src/sfsg_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sfsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sfsg_scale_pipe.sv -----
// Three-stage coordinate scaler: v * scale / 25600, truncated toward zero.
`timescale 1ns / 1ps

module sfsg_scale_pipe
   import sfsg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  tok_type                    in_tok,
   input  logic signed [VERT_W-1:0]   in_x,
   input  logic signed [VERT_W-1:0]   in_y,
   input  logic [SCALE_W-1:0]         scale,
   output tok_type                    out_tok,
   output logic signed [SCALED_W-1:0] out_x,
   output logic signed [SCALED_W-1:0] out_y,
   output logic                       busy
);

   // lane 0 is x, lane 1 is y
   tok_type                    tok1_ff, tok2_ff, tok3_ff;
   logic signed [PROD_W-1:0]   prod_ff [2];
   logic signed [PROD_W-1:0]   prod_in [2];
   logic [Q_W-1:0]             q_ff    [2];
   logic [Q_W-1:0]             q_in    [2];
   logic                       neg_ff  [2];
   logic signed [SCALED_W-1:0] res_ff  [2];
   logic signed [SCALED_W-1:0] res_in  [2];
   logic signed [PROD_W-1:0]   mag_full;
   logic [MAG_W-1:0]           mag;
   logic [QUO_W-1:0]           quo;
   logic signed [SCALED_W-1:0] quo_s;

   always_comb begin
      prod_in[0] = in_x * $signed({1'b0, scale});
      prod_in[1] = in_y * $signed({1'b0, scale});
      mag_full   = '0;
      mag        = '0;
      quo        = '0;
      quo_s      = '0;
      for (int i = 0; i < 2; i++) begin
         // magnitude, then drop the power-of-two part of 25600
         mag_full  = prod_ff[i][PROD_W-1] ? -prod_ff[i] : prod_ff[i];
         mag       = mag_full[MAG_W+UNIT_SHIFT-1:UNIT_SHIFT];
         q_in[i]   = Q_W'(mag) * Q_W'(DIV_MUL);
         quo       = q_ff[i][Q_W-1:DIV_SHIFT];
         quo_s     = $signed({1'b0, quo});
         res_in[i] = neg_ff[i] ? -quo_s : quo_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         tok3_ff <= '0;
      end else if (en) begin
         tok1_ff <= in_tok;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) begin
            prod_ff[i] <= prod_in[i];
            q_ff[i]    <= q_in[i];
            neg_ff[i]  <= prod_ff[i][PROD_W-1];
            res_ff[i]  <= res_in[i];
         end
      end
   end

   assign out_tok = tok3_ff;
   assign out_x   = res_ff[0];
   assign out_y   = res_ff[1];
   assign busy    = tok1_ff.valid || tok2_ff.valid || tok3_ff.valid;

endmodule

// ----- src/sfsg_walker.sv -----
// Table walker: reads glyph and path entries and issues vertex reads in order.
`timescale 1ns / 1ps

module sfsg_walker
   import sfsg_pkg::*;
#(
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
   parameter int PATH_DEPTH   = DEF_PATH_DEPTH,
   parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   localparam int GW      = $clog2(GLYPH_COUNT),
   localparam int PPW     = $clog2(PATH_DEPTH),
   localparam int VPW     = $clog2(VERTEX_DEPTH),
   localparam int GLYPH_W = ADV_W + COUNT_W + PPW,
   localparam int PATH_W  = COUNT_W + VPW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               draw_start,
   input  logic [7:0]         code,
   output logic               glyph_rd_en,
   output logic [GW-1:0]      glyph_rd_addr,
   input  logic [GLYPH_W-1:0] glyph_rd_data,
   output logic               path_rd_en,
   output logic [PPW-1:0]     path_rd_addr,
   input  logic [PATH_W-1:0]  path_rd_data,
   output logic               vert_rd_en,
   output logic [VPW-1:0]     vert_rd_addr,
   output tok_type            tok,
   output logic [ADV_W-1:0]   adv,
   input  logic               pipe_busy,
   output logic               idle
);

   localparam int SCW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [2:0] {
      IDLE,
      GLYPH,
      PATH_NEXT,
      PATH_WAIT,
      VERT,
      ADV,
      DRAIN
   } walk_state_type;

   walk_state_type       state_ff, state_in;
   tok_type              tok_ff, tok_in;
   logic [PPW-1:0]       path_ptr_ff, path_ptr_in;
   logic [COUNT_W-1:0]   path_left_ff, path_left_in;
   logic [VPW-1:0]       vert_ptr_ff, vert_ptr_in;
   logic [COUNT_W-1:0]   vert_left_ff, vert_left_in;
   logic                 first_ff, first_in;
   logic [SCW-1:0]       seg_cnt_ff, seg_cnt_in;
   logic [ADV_W-1:0]     adv_ff, adv_in;
   logic [COUNT_W-1:0]   p_count;

   assign p_count = path_rd_data[PATH_W-1:VPW];

   always_comb begin
      state_in      = state_ff;
      tok_in        = en ? '0 : tok_ff;
      path_ptr_in   = path_ptr_ff;
      path_left_in  = path_left_ff;
      vert_ptr_in   = vert_ptr_ff;
      vert_left_in  = vert_left_ff;
      first_in      = first_ff;
      seg_cnt_in    = seg_cnt_ff;
      adv_in        = adv_ff;
      glyph_rd_en   = 1'b0;
      glyph_rd_addr = code[GW-1:0];
      path_rd_en    = 1'b0;
      path_rd_addr  = path_ptr_ff;
      vert_rd_en    = 1'b0;
      vert_rd_addr  = vert_ptr_ff;
      case (state_ff)
         IDLE: begin
            if (draw_start) begin
               glyph_rd_en = 1'b1;
               state_in    = GLYPH;
            end
         end
         GLYPH: begin
            path_ptr_in  = glyph_rd_data[PPW-1:0];
            path_left_in = glyph_rd_data[PPW+COUNT_W-1:PPW];
            adv_in       = glyph_rd_data[GLYPH_W-1:PPW+COUNT_W];
            seg_cnt_in   = '0;
            state_in     = PATH_NEXT;
         end
         PATH_NEXT: begin
            if (path_left_ff == '0) begin
               state_in = ADV;
            end else begin
               path_rd_en   = 1'b1;
               path_ptr_in  = (path_ptr_ff == PPW'(PATH_DEPTH - 1)) ? '0
                                                                    : path_ptr_ff + 1'b1;
               path_left_in = path_left_ff - 1'b1;
               state_in     = PATH_WAIT;
            end
         end
         PATH_WAIT: begin
            vert_ptr_in  = path_rd_data[VPW-1:0];
            vert_left_in = p_count;
            first_in     = 1'b1;
            state_in     = (p_count < COUNT_W'(2)) ? PATH_NEXT : VERT;
         end
         VERT: begin
            if (en) begin
               if (!first_ff && seg_cnt_ff == SCW'(MAX_SEGMENTS)) begin
                  // segment budget spent: skip the rest of the glyph
                  state_in = ADV;
               end else begin
                  vert_rd_en   = 1'b1;
                  tok_in.valid = 1'b1;
                  tok_in.kind  = first_ff ? TOK_FIRST : TOK_NEXT;
                  vert_ptr_in  = (vert_ptr_ff == VPW'(VERTEX_DEPTH - 1)) ? '0
                                                                        : vert_ptr_ff + 1'b1;
                  vert_left_in = vert_left_ff - 1'b1;
                  first_in     = 1'b0;
                  if (!first_ff) begin
                     seg_cnt_in = seg_cnt_ff + 1'b1;
                  end
                  if (vert_left_ff == COUNT_W'(1)) begin
                     state_in = PATH_NEXT;
                  end
               end
            end
         end
         ADV: begin
            if (en) begin
               tok_in.valid = 1'b1;
               tok_in.kind  = TOK_ADV;
               state_in     = DRAIN;
            end
         end
         DRAIN: begin
            // pen x is written when the advance token leaves the pipe
            if (!tok_ff.valid && !pipe_busy) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         tok_ff       <= '0;
         path_ptr_ff  <= '0;
         path_left_ff <= '0;
         vert_ptr_ff  <= '0;
         vert_left_ff <= '0;
         first_ff     <= 1'b0;
         seg_cnt_ff   <= '0;
         adv_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         tok_ff       <= tok_in;
         path_ptr_ff  <= path_ptr_in;
         path_left_ff <= path_left_in;
         vert_ptr_ff  <= vert_ptr_in;
         vert_left_ff <= vert_left_in;
         first_ff     <= first_in;
         seg_cnt_ff   <= seg_cnt_in;
         adv_ff       <= adv_in;
      end
   end

   assign tok  = tok_ff;
   assign adv  = adv_ff;
   assign idle = (state_ff == IDLE);

`ifndef SYNTHESIS
   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !tok_ff.valid)
      else $error("walker idle with a token in flight");

   a_seg_budget: assert property (@(posedge clock) disable iff (reset)
      seg_cnt_ff <= SCW'(MAX_SEGMENTS))
      else $error("segment count beyond budget");

   a_path_wait_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == PATH_WAIT |-> $past(state_ff) == PATH_NEXT)
      else $error("path data captured without a path read");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the stroke font segment generator: loads fonts, draws, checks segments.
`timescale 1ns / 1ps

// How it works:
// - An initial block builds the word stream in phases and pushes it onto cmd_queue.
//   It keeps a planned copy of the font stores. With that copy it never issues a draw
//   that would walk an entry that was never loaded. Such a draw is turned into a
//   code of 128 or more, which the block ignores.
// - The request driver takes words from cmd_queue and offers them on req_*.
//   When the block accepts a word, the driver applies it to the live copy of the
//   stores. A draw walks the glyph there and appends the expected segments to
//   segments_due.
// - The response monitor pops segments_due in order and compares each field.
// - The scale is changed only when the block is quiet: every word has been taken,
//   every segment has been seen, and a settle delay has passed.
// - Both sides idle at random. Once, the receiver holds off for a long stretch
//   while draws keep coming, so that the block backs up into its input.
module tb_top
   import sfsg_pkg::*;
;

   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          SETTLE_CYCLES = 200;    // longest draw that emits nothing
   localparam int          LONG_HOLD     = 300;
   localparam logic [17:0] SCALE_MAX     = 18'((2 ** SCALE_W) - 1);
   localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;  // modes above draw are ignored
   localparam int          PLAN = 0;               // stores as of the last queued word
   localparam int          LIVE = 1;               // stores as of the last accepted word

   // one request word, fields as the block sees them
   typedef struct packed {
      logic [2:0]         mode;
      logic [11:0]        table_index;
      logic [7:0]         char_code;
      logic signed [15:0] pen_x;
      logic signed [15:0] pen_y;
      logic [11:0]        start_index;
      logic [5:0]         item_count;
      logic [7:0]         adv_width;
      logic signed [9:0]  vertex_x;
      logic signed [9:0]  vertex_y;
   } font_cmd_type;

   typedef struct packed {
      logic [15:0] x1;
      logic [15:0] y1;
      logic [15:0] x2;
      logic [15:0] y2;
      logic        last;
   } stroke_seg_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [103:0]        req_tdata = '0;
   logic [2:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [63:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic [SCALE_W-1:0]  csr_wdata = '0;

   // font stores, planned and live copies
   logic [9:0]         glyph_first [2][DEF_GLYPH_COUNT];
   logic [5:0]         glyph_paths [2][DEF_GLYPH_COUNT];
   logic [7:0]         glyph_adv   [2][DEF_GLYPH_COUNT];
   bit                 glyph_set   [2][DEF_GLYPH_COUNT];
   logic [11:0]        path_first  [2][DEF_PATH_DEPTH];
   logic [5:0]         path_verts  [2][DEF_PATH_DEPTH];
   bit                 path_set    [2][DEF_PATH_DEPTH];
   logic signed [9:0]  vert_x      [2][DEF_VERTEX_DEPTH];
   logic signed [9:0]  vert_y      [2][DEF_VERTEX_DEPTH];
   bit                 vert_set    [2][DEF_VERTEX_DEPTH];

   logic signed [15:0] pen_x_now = '0;
   logic signed [15:0] pen_y_now = '0;
   logic [17:0]        scale_now = SCALE_RESET;

   font_cmd_type   cmd_queue[$];
   stroke_seg_type segments_due[$];
   int             built_codes[$];
   font_cmd_type   offered;
   int        cmds_queued = 0;
   int        cmds_accepted = 0;
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_gap = 0;
   int        stall_left = 0;
   int        holds_asked = 0;
   int        holds_begun = 0;
   bit        sender_idle_on = 1'b1;
   bit        receiver_idle_on = 1'b1;

   stroke_font_segment_generator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   // font units to screen units around the pen; y flips since screen y runs down
   function automatic logic [15:0] to_screen(input logic signed [15:0] pen,
                                             input logic signed [9:0] v, input bit flip);
      longint d;
      d = (longint'(v) * longint'(scale_now)) / UNIT_SCALE;
      return 16'(flip ? longint'(pen) - d : longint'(pen) + d);
   endfunction

   // a load word lands in one copy of the stores; out-of-range indexes are dropped
   function automatic void file_entry(input int view, input font_cmd_type c);
      case (c.mode)
         MODE_LOAD_GLYPH: begin
            if (c.table_index < DEF_GLYPH_COUNT) begin
               glyph_first[view][c.table_index] = 10'(c.start_index % DEF_PATH_DEPTH);
               glyph_paths[view][c.table_index] = c.item_count;
               glyph_adv[view][c.table_index]   = c.adv_width;
               glyph_set[view][c.table_index]   = 1'b1;
            end
         end
         MODE_LOAD_PATH: begin
            if (c.table_index < DEF_PATH_DEPTH) begin
               path_first[view][c.table_index] = 12'(c.start_index % DEF_VERTEX_DEPTH);
               path_verts[view][c.table_index] = c.item_count;
               path_set[view][c.table_index]   = 1'b1;
            end
         end
         MODE_LOAD_VERTEX: begin
            if (c.table_index < DEF_VERTEX_DEPTH) begin
               vert_x[LIVE == view ? LIVE : PLAN][c.table_index] = c.vertex_x;
               vert_y[view][c.table_index]   = c.vertex_y;
               vert_set[view][c.table_index] = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // true when drawing this code touches only loaded entries (planned copy)
   function automatic bit draw_ok(input logic [7:0] code);
      int p;
      int need;
      if (code >= CODE_LIMIT || code >= DEF_GLYPH_COUNT) return 1'b1;
      if (!glyph_set[PLAN][code]) return 1'b0;
      for (int i = 0; i < glyph_paths[PLAN][code]; i++) begin
         p = (int'(glyph_first[PLAN][code]) + i) % DEF_PATH_DEPTH;
         if (!path_set[PLAN][p]) return 1'b0;
         need = (path_verts[PLAN][p] == 0) ? 1 : int'(path_verts[PLAN][p]);
         for (int m = 0; m < need; m++) begin
            if (!vert_set[PLAN][(int'(path_first[PLAN][p]) + m) % DEF_VERTEX_DEPTH])
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // walk one glyph in the live copy, queue its segments, advance the pen
   task automatic trace_glyph(input logic [7:0] code);
      stroke_seg_type strokes[$];
      stroke_seg_type s;
      int p;
      int v;
      if (code >= CODE_LIMIT || code >= DEF_GLYPH_COUNT) return;
      for (int i = 0; i < glyph_paths[LIVE][code]; i++) begin
         p = (int'(glyph_first[LIVE][code]) + i) % DEF_PATH_DEPTH;
         if (path_verts[LIVE][p] < 2) continue;   // a lone point draws nothing
         v = int'(path_first[LIVE][p]);
         s.x1 = to_screen(pen_x_now, vert_x[LIVE][v], 1'b0);
         s.y1 = to_screen(pen_y_now, vert_y[LIVE][v], 1'b1);
         for (int m = 1; m < path_verts[LIVE][p]; m++) begin
            v = (int'(path_first[LIVE][p]) + m) % DEF_VERTEX_DEPTH;
            s.x2 = to_screen(pen_x_now, vert_x[LIVE][v], 1'b0);
            s.y2 = to_screen(pen_y_now, vert_y[LIVE][v], 1'b1);
            s.last = 1'b0;
            // segments past the cap are dropped, the walk goes on
            if (strokes.size() < DEF_MAX_SEGMENTS) strokes.push_back(s);
            s.x1 = s.x2;
            s.y1 = s.y2;
         end
      end
      foreach (strokes[k]) begin
         s = strokes[k];
         s.last = (k == strokes.size() - 1);
         segments_due.push_back(s);
      end
      pen_x_now = 16'(longint'(pen_x_now) +
                      (longint'(glyph_adv[LIVE][code]) * longint'(scale_now)) / UNIT_SCALE);
   endtask

   task automatic apply_cmd(input font_cmd_type c);
      file_entry(LIVE, c);
      if (c.mode == MODE_SET_PEN) begin
         pen_x_now = c.pen_x;
         pen_y_now = c.pen_y;
      end else if (c.mode == MODE_DRAW) begin
         trace_glyph(c.char_code);
      end
   endtask

   // ------------------------------------------------------------ stimulus

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // every field random, so bits the mode does not use still toggle
   function automatic font_cmd_type random_cmd(input logic [2:0] mode);
      logic [127:0] bits;
      font_cmd_type c;
      bits = {$urandom, $urandom, $urandom, $urandom};
      c = bits[$bits(font_cmd_type)-1:0];
      c.mode = mode;
      return c;
   endfunction

   task automatic enqueue(input font_cmd_type c);
      if (c.mode == MODE_DRAW && !draw_ok(c.char_code)) c.char_code[7] = 1'b1;
      file_entry(PLAN, c);
      cmd_queue.push_back(c);
      cmds_queued++;
   endtask

   task automatic queue_vertex(input int idx, input int x, input int y);
      font_cmd_type c;
      c = random_cmd(MODE_LOAD_VERTEX);
      c.table_index = 12'(idx);
      c.vertex_x = 10'(x);
      c.vertex_y = 10'(y);
      enqueue(c);
   endtask

   task automatic queue_path(input int idx, input int first, input int cnt);
      font_cmd_type c;
      c = random_cmd(MODE_LOAD_PATH);
      c.table_index = 12'(idx);
      c.start_index = 12'(first);
      c.item_count = 6'(cnt);
      enqueue(c);
   endtask

   task automatic queue_glyph(input int idx, input int first, input int cnt, input int w);
      font_cmd_type c;
      c = random_cmd(MODE_LOAD_GLYPH);
      c.table_index = 12'(idx);
      c.start_index = 12'(first);
      c.item_count = 6'(cnt);
      c.adv_width = 8'(w);
      enqueue(c);
   endtask

   task automatic queue_pen(input int x, input int y);
      font_cmd_type c;
      c = random_cmd(MODE_SET_PEN);
      c.pen_x = 16'(x);
      c.pen_y = 16'(y);
      enqueue(c);
   endtask

   task automatic queue_draw(input int code);
      font_cmd_type c;
      c = random_cmd(MODE_DRAW);
      c.char_code = 8'(code);
      enqueue(c);
   endtask

   function automatic int pick_code();
      if (built_codes.size() > 0 && $urandom_range(0, 4) != 0)
         return built_codes[$urandom_range(0, built_codes.size() - 1)];
      return $urandom_range(0, 255);
   endfunction

   // a well-formed character: vertices, paths over them, glyph, optional pen, one or two draws
   task automatic queue_random_glyph();
      int code;
      int npath;
      int pbase;
      int vbase;
      int nvert;
      int off;
      code  = $urandom_range(0, DEF_GLYPH_COUNT - 1);
      npath = $urandom_range(1, 3);
      pbase = $urandom_range(0, DEF_PATH_DEPTH - 1);
      vbase = $urandom_range(0, DEF_VERTEX_DEPTH - 1);
      nvert = $urandom_range(2, 7);
      for (int k = 0; k < nvert; k++)
         queue_vertex((vbase + k) % DEF_VERTEX_DEPTH, int'($urandom), int'($urandom));
      for (int j = 0; j < npath; j++) begin
         off = $urandom_range(0, nvert - 2);
         queue_path((pbase + j) % DEF_PATH_DEPTH, vbase + off,
                    ($urandom_range(0, 9) < 8) ? nvert - off : $urandom_range(0, 1));
      end
      // start above the path depth on purpose now and then; it wraps
      queue_glyph(code, pbase + DEF_PATH_DEPTH * $urandom_range(0, 3), npath,
                  $urandom_range(0, 255));
      if ($urandom_range(0, 1) != 0) queue_pen(int'($urandom), int'($urandom));
      queue_draw(code);
      if ($urandom_range(0, 2) == 0) queue_draw(code);
      built_codes.push_back(code);
   endtask

   // block is quiet: all words taken, all segments back, then a settle delay
   task automatic wait_quiet();
      do @(posedge clock);
      while (cmds_accepted != cmds_queued || segments_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_scale(input logic [17:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      scale_now = value;
   endtask

   initial begin : stimulus
      int target;
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes at unit scale
      queue_vertex(0, -512, 511);
      queue_vertex(1, 511, -512);
      queue_vertex(2, 0, 0);
      queue_vertex(3, -1, 1);
      queue_vertex(4, 100, -37);
      queue_vertex(5, -250, 300);
      queue_vertex(6, 7, -7);
      queue_vertex(7, 511, 511);
      queue_vertex(DEF_VERTEX_DEPTH - 2, -512, -512);
      queue_vertex(DEF_VERTEX_DEPTH - 1, 3, -3);
      queue_path(0, 0, 8);
      queue_path(1, DEF_VERTEX_DEPTH - 2, 4);     // vertex walk wraps past the end
      queue_path(2, 5, 1);                        // single point, no segment
      queue_path(3, 2, 0);                        // empty path
      queue_path(DEF_PATH_DEPTH - 1, 4, 4);
      queue_path(2000, 0, 63);                    // index past the path store, dropped
      queue_glyph(0, 0, 4, 255);
      queue_glyph(127, 4095, 2, 0);               // start wraps to last path, walk wraps to 0
      queue_glyph(65, 2, 2, 10);                  // advances but draws nothing
      queue_glyph(200, 0, 63, 255);               // index past the glyph store, dropped
      enqueue(random_cmd(MODE_UNUSED_HI));
      queue_draw(0);
      queue_draw(65);
      queue_pen(-32768, 32767);                   // coordinates wrap around 16 bits
      queue_draw(127);
      queue_draw(0);
      queue_draw(128);
      queue_draw(255);
      wait_quiet();

      // largest scale, segment cap, long receiver hold with draws backing up
      set_scale(SCALE_MAX);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      for (int j = 0; j < 8; j++) queue_path(10 + j, DEF_VERTEX_DEPTH - 2, 10);
      queue_glyph(5, 10, 8, 200);                 // 72 segments, only 64 come out
      queue_pen(0, 0);
      holds_asked++;
      queue_draw(5);
      queue_draw(5);
      queue_draw(0);
      queue_draw(127);
      queue_draw(1);                              // never loaded, gets ignored
      wait_quiet();

      // zero scale: every point collapses onto the pen
      set_scale(0);
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      queue_pen(int'($urandom), int'($urandom));
      queue_draw(0);
      queue_draw(5);
      queue_draw(65);
      wait_quiet();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: set_scale(18'($urandom_range(1, int'(SCALE_MAX) - 1)));
            1: set_scale(18'($urandom_range(6400, 51200)));
            default: set_scale(SCALE_RESET);
         endcase
         sender_idle_on = (ph != 2);
         receiver_idle_on = (ph != 1);
         target = cmds_queued + 15;
         while (cmds_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) queue_random_glyph();
            else if (r < 70) queue_draw(pick_code());
            else enqueue(random_cmd(3'($urandom_range(int'(MODE_LOAD_GLYPH),
                                                      int'(MODE_UNUSED_HI)))));
         end
         wait_quiet();
      end

      if (error_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   // ------------------------------------------------------ request driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_cmd(offered);
            cmds_accepted++;
            send_gap = sender_idle_on ? pick_pause() : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               offered = cmd_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, offered.vertex_y, offered.vertex_x, offered.adv_width,
                             offered.item_count, offered.start_index, offered.pen_y,
                             offered.pen_x, offered.char_code, offered.table_index};
               req_tuser <= offered.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------ response side

   // ready: random short stalls, plus the one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (holds_begun != holds_asked && rsp_tvalid) begin
            holds_begun++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_pause();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch_segments
      stroke_seg_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (segments_due.size() == 0) begin
            $display("%0t: segment with none pending, expected nothing actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = segments_due.pop_front();
            check_field("seg_x1", want.x1, rsp_tdata[15:0]);
            check_field("seg_y1", want.y1, rsp_tdata[31:16]);
            check_field("seg_x2", want.x2, rsp_tdata[47:32]);
            check_field("seg_y2", want.y2, rsp_tdata[63:48]);
            check_field("last_segment", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule

// ----- files.f -----
src/sfsg_pkg.sv
src/sfsg_ram.sv
src/sfsg_scale_pipe.sv
src/sfsg_walker.sv
src/stroke_font_segment_generator_unit.sv
bench/tb_top.sv
